@@ hdl/rrp_pkg.sv @@
// Package for the per-endpoint round-robin pick block.
// Holds the fixed field widths and the parameter defaults; no dependencies.
package rrp_pkg;

    // Fixed widths of the beat fields
    localparam int ENDPOINT_W = 3;
    localparam int MASK_W     = 16;
    localparam int SLOT_W     = 4;

    // Defaults for the top-level parameters
    localparam int DEF_SENDER_SLOTS = 16;
    localparam int DEF_ENDPOINTS    = 8;

endpackage

@@ hdl/rrp_slot_search.sv @@
// Round-robin search of one pending mask from a start position.
// Pure combinational logic; takes the default slot count from rrp_pkg.
module rrp_slot_search
    import rrp_pkg::*;
#(
    parameter int SENDER_SLOTS = DEF_SENDER_SLOTS,
    parameter int START_W      = $clog2(SENDER_SLOTS + 1),
    parameter int IDX_W        = $clog2(SENDER_SLOTS)
)
(
    input  logic [START_W-1:0]      start,
    input  logic [SENDER_SLOTS-1:0] mask,
    output logic                    hit,
    output logic [IDX_W-1:0]        pick,
    output logic [START_W-1:0]      next_start
);

    logic [SENDER_SLOTS-1:0] upper;
    logic [IDX_W-1:0]        pick_upper;
    logic [IDX_W-1:0]        pick_any;

    // Keep only slots at or above the start
    always_comb
    begin
        for (int i = 0; i < SENDER_SLOTS; i++)
        begin
            upper[i] = mask[i] && (START_W'(i) >= start);
        end
    end

    // Lowest set bit of each mask
    always_comb
    begin
        pick_upper = '0;
        pick_any   = '0;
        for (int i = SENDER_SLOTS - 1; i >= 0; i--)
        begin
            if (upper[i])
            begin
                pick_upper = IDX_W'(i);
            end
            if (mask[i])
            begin
                pick_any = IDX_W'(i);
            end
        end
    end

    // Wrap to the low slots when nothing is pending above the start
    always_comb
    begin
        hit  = |mask;
        pick = (|upper) ? pick_upper : pick_any;
        if (hit)
        begin
            next_start = START_W'(pick) + START_W'(1);
        end
        else
        begin
            next_start = '0;
        end
    end

endmodule

@@ hdl/rrp_start_table.sv @@
// Per-endpoint start position registers with one read and one write port.
// Uses rrp_pkg defaults; cleared to zero by reset.
module rrp_start_table
    import rrp_pkg::*;
#(
    parameter int ENDPOINTS = DEF_ENDPOINTS,
    parameter int START_W   = 5,
    parameter int EP_IDX_W  = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [EP_IDX_W-1:0] rd_idx,
    output logic [START_W-1:0]  rd_data,
    input  logic                wr_en,
    input  logic [EP_IDX_W-1:0] wr_idx,
    input  logic [START_W-1:0]  wr_data
);

    logic [START_W-1:0] start_reg [ENDPOINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENDPOINTS; e++)
            begin
                start_reg[e] <= '0;
            end
        end
        else if (wr_en)
        begin
            start_reg[wr_idx] <= wr_data;
        end
    end

    // Drop the read for an endpoint outside the table
    assign rd_data = rd_en ? start_reg[rd_idx] : '0;

endmodule

@@ hdl/per_endpoint_round_robin_pick.sv @@
// Top level of the per-endpoint round-robin pick block.
// Depends on rrp_pkg, rrp_start_table and rrp_slot_search.
//
// Use:
//   Input channel (in_valid / in_ready) carries one beat per request: an
//   endpoint number and the mask of its sender slots that hold a message.
//   Output channel (out_valid / out_ready) returns one beat per request:
//   found, and chosen_slot (0 when nothing is pending).
//   Each endpoint keeps a start position. The search runs upward from it,
//   then wraps to the slots below; the slot after the pick becomes the new
//   start, and an empty mask sets the start back to 0. An endpoint at or
//   above ENDPOINTS gives found 0 and leaves every start untouched.
// Pipeline and throughput:
//   A beat accepted is registered in the input stage, searched there by
//   combinational logic and loaded into the result register once that
//   register frees; out_valid comes from the result register, so the
//   output beat can be taken only after that load.
//   One beat per cycle is sustained while out_ready stays high: the start
//   table is written at the same edge the result register loads, so the
//   next beat, even for the same endpoint, already reads the updated start.
// Reset:
//   rst_n clears both stage valids and every start position to 0.
// Stall:
//   While out_ready is low a waiting result stays put; the input stage still
//   takes one more beat, then in_ready drops until the result is taken.
module per_endpoint_round_robin_pick
    import rrp_pkg::*;
#(
    parameter int SENDER_SLOTS = DEF_SENDER_SLOTS,
    parameter int ENDPOINTS    = DEF_ENDPOINTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ENDPOINT_W-1:0] endpoint,
    input  logic [MASK_W-1:0]     pending_mask,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [SLOT_W-1:0]     chosen_slot
);

    localparam int START_W  = $clog2(SENDER_SLOTS + 1);
    localparam int IDX_W    = $clog2(SENDER_SLOTS);
    localparam int EP_IDX_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int EP_EXT_W = (EP_IDX_W > ENDPOINT_W) ? EP_IDX_W : ENDPOINT_W;
    localparam int MSK_EXT_W = (SENDER_SLOTS > MASK_W) ? SENDER_SLOTS : MASK_W;
    localparam int SEL_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // Input stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [ENDPOINT_W-1:0] s1_endpoint_reg;
    logic [MASK_W-1:0]     s1_mask_reg;

    // Result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  found_reg;
    logic [SLOT_W-1:0]     chosen_slot_reg;

    logic                    advance;
    logic                    in_accept;
    logic                    ep_in_range;
    logic [EP_EXT_W-1:0]     ep_ext;
    logic [EP_IDX_W-1:0]     ep_idx;
    logic [MSK_EXT_W-1:0]    mask_ext;
    logic [SENDER_SLOTS-1:0] slot_mask;
    logic [START_W-1:0]      cur_start;
    logic                    hit;
    logic [IDX_W-1:0]        pick;
    logic [START_W-1:0]      next_start;
    logic [SEL_W-1:0]        pick_ext;

    // Result register frees when empty or taken; input stage moves with it
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_endpoint_reg <= endpoint;
            s1_mask_reg     <= pending_mask;
        end
    end

    // Endpoint decode; ignore endpoints beyond the table
    assign ep_in_range = (32'(s1_endpoint_reg) < ENDPOINTS);
    assign ep_ext      = EP_EXT_W'(s1_endpoint_reg);
    assign ep_idx      = ep_ext[EP_IDX_W-1:0];

    // Drop mask bits above the slot count
    assign mask_ext  = MSK_EXT_W'(s1_mask_reg);
    assign slot_mask = mask_ext[SENDER_SLOTS-1:0];

    rrp_start_table #(
        .ENDPOINTS (ENDPOINTS),
        .START_W   (START_W),
        .EP_IDX_W  (EP_IDX_W)
    ) u_start_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ep_in_range),
        .rd_idx  (ep_idx),
        .rd_data (cur_start),
        .wr_en   (s1_valid_reg && advance && ep_in_range),
        .wr_idx  (ep_idx),
        .wr_data (next_start)
    );

    rrp_slot_search #(
        .SENDER_SLOTS (SENDER_SLOTS),
        .START_W      (START_W),
        .IDX_W        (IDX_W)
    ) u_slot_search (
        .start      (cur_start),
        .mask       (slot_mask),
        .hit        (hit),
        .pick       (pick),
        .next_start (next_start)
    );

    assign pick_ext = SEL_W'(pick);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result beat; zero it for an empty mask or a bad endpoint
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            found_reg       <= hit && ep_in_range;
            chosen_slot_reg <= (hit && ep_in_range) ? pick_ext[SLOT_W-1:0] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign chosen_slot = chosen_slot_reg;

    // A result without a hit carries slot zero
    a_no_hit_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (chosen_slot_reg == '0))
        else $error("empty result with nonzero chosen_slot");

    // A picked slot lies inside the slot range
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (32'(chosen_slot_reg) < SENDER_SLOTS))
        else $error("chosen_slot beyond sender slots");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // A bad endpoint moving on yields an empty result
    a_bad_endpoint_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !ep_in_range) |=> (out_valid_reg && !found_reg))
        else $error("out-of-range endpoint produced a hit");

endmodule

@@ verif/testbench.sv @@
// Testbench for per_endpoint_round_robin_pick: random and directed pick requests with
// a round-robin scoreboard that predicts found / chosen_slot per beat.
// Depends on rrp_pkg and the per_endpoint_round_robin_pick RTL only.
`timescale 1ns / 1ps

module testbench;
    import rrp_pkg::*;

    localparam int SLOTS         = DEF_SENDER_SLOTS;
    localparam int EPS           = DEF_ENDPOINTS;
    localparam int RANDOM_BEATS  = 1750;
    localparam int CALM_BEATS    = 200;
    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 20;

    // One expected result beat
    typedef struct packed
    {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } pick_t;

    // Scoreboard: keeps its own start table, predicts each pick at input accept
    // and compares every output beat with the oldest prediction.
    class pick_scoreboard;
        bit [4:0]    start_pos [EPS];
        pick_t       expected_q [$];
        int unsigned errors;
        int unsigned hits;
        int unsigned misses;

        function new();
            foreach (start_pos[e])
                start_pos[e] = '0;
            errors = 0;
            hits   = 0;
            misses = 0;
        endfunction

        function void note_request(logic [ENDPOINT_W-1:0] ep, logic [MASK_W-1:0] mask);
            int unsigned first;
            int unsigned pick;
            int unsigned i;
            bit          hit;
            pick_t       p;
            p    = '0;
            hit  = 1'b0;
            pick = 0;
            if (ep < EPS)
            begin
                first = start_pos[ep];
                if (first > SLOTS)
                    first = 0;
                // search upward from the start, then wrap to the slots below it
                for (i = first; i < SLOTS && !hit; i++)
                    if (mask[i])
                    begin
                        hit  = 1'b1;
                        pick = i;
                    end
                for (i = 0; i < first && !hit; i++)
                    if (mask[i])
                    begin
                        hit  = 1'b1;
                        pick = i;
                    end
                if (hit)
                begin
                    start_pos[ep] = 5'(pick + 1);
                    p.found       = 1'b1;
                    p.slot        = SLOT_W'(pick);
                end
                else
                    start_pos[ep] = '0;
            end
            if (p.found)
                hits++;
            else
                misses++;
            expected_q.push_back(p);
        endfunction

        function void check_pick(logic found, logic [SLOT_W-1:0] slot);
            pick_t exp_p;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: found %0b slot %0d",
                         $time, found, slot);
                errors++;
                return;
            end
            exp_p = expected_q.pop_front();
            if (found !== exp_p.found)
            begin
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $time, exp_p.found, found);
                errors++;
            end
            if (slot !== exp_p.slot)
            begin
                $display("%0t: chosen_slot mismatch: expected %0d actual %0d",
                         $time, exp_p.slot, slot);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [ENDPOINT_W-1:0] endpoint     = '0;
    logic [MASK_W-1:0]     pending_mask = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  found;
    logic [SLOT_W-1:0]     chosen_slot;

    // Set for the last stretch of the run: no idling on either side
    bit                    calm = 1'b0;
    pick_scoreboard        sb;

    per_endpoint_round_robin_pick #(
        .SENDER_SLOTS(SLOTS),
        .ENDPOINTS   (EPS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .endpoint    (endpoint),
        .pending_mask(pending_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .chosen_slot (chosen_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sample both channels at the rising edge; all inputs change only through
    // nonblocking assignments, so these reads see the pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(endpoint, pending_mask);
        if (rst_n && out_valid && out_ready)
            sb.check_pick(found, chosen_slot);
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // Output side: hold ready low in bursts of random length, except
    // in the calm stretch at the end.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Present one beat and hold it until accepted. Call at a rising edge;
    // returns at the edge where the beat was taken.
    task automatic send_request(input logic [ENDPOINT_W-1:0] ep,
                                input logic [MASK_W-1:0] mask);
        in_valid     <= 1'b1;
        endpoint     <= ep;
        pending_mask <= mask;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Maybe drop valid for a random burst, then send the beat.
    task automatic issue(input logic [ENDPOINT_W-1:0] ep, input logic [MASK_W-1:0] mask);
        int unsigned gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_request(ep, mask);
    endtask

    // Mask mix: empty, full, single and double bits, and fully random.
    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        m = '0;
        case ($urandom_range(0, 9))
            0:
                m = '0;
            1:
                m = '1;
            2, 3, 4:
                m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            5:
            begin
                m[$urandom_range(0, MASK_W - 1)] = 1'b1;
                m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            end
            default:
                m = MASK_W'($urandom);
        endcase
        return m;
    endfunction

    initial
    begin : stimulus
        int unsigned           n;
        logic [ENDPOINT_W-1:0] hot_ep;
        logic [ENDPOINT_W-1:0] ep;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty mask, full mask stepping, top slot with the start
        // landing at the wrap, and the empty mask resetting the start.
        issue(3'd0, 16'h0000);
        issue(3'd0, 16'hFFFF);
        issue(3'd0, 16'hFFFF);
        issue(3'd0, 16'h8000);
        issue(3'd0, 16'h8001);
        issue(3'd0, 16'h8000);
        issue(3'd0, 16'h8000);
        issue(3'd0, 16'h0001);
        issue(3'd7, 16'h0001);
        issue(3'd7, 16'h0001);
        issue(3'd7, 16'h0003);
        issue(3'd7, 16'h0003);
        issue(3'd1, 16'h0010);
        issue(3'd1, 16'h0000);
        issue(3'd1, 16'h0011);
        issue(3'd1, 16'h0011);
        issue(3'd1, 16'h0011);
        issue(3'd2, 16'hAAAA);
        issue(3'd2, 16'hAAAA);
        issue(3'd3, 16'h5555);
        issue(3'd4, 16'h8000);
        issue(3'd5, 16'h4000);
        issue(3'd6, 16'hFFFF);
        issue(3'd6, 16'h7FFF);

        // Random: bias toward one hot endpoint so the same endpoint often comes
        // back to back and the start-table update is exercised under load.
        hot_ep = ENDPOINT_W'($urandom_range(0, (1 << ENDPOINT_W) - 1));
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS - CALM_BEATS)
                calm = 1'b1;
            if ($urandom_range(0, 31) == 0)
                hot_ep = ENDPOINT_W'($urandom_range(0, (1 << ENDPOINT_W) - 1));
            if ($urandom_range(0, 2) == 0)
                ep = hot_ep;
            else
                ep = ENDPOINT_W'($urandom_range(0, (1 << ENDPOINT_W) - 1));
            issue(ep, random_mask());
        end
        in_valid <= 1'b0;

        // Drain: wait for every predicted beat, then idle before the summary.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pick requests over %0d endpoints: %0d found, %0d empty.",
                 sb.hits + sb.misses, EPS, sb.hits, sb.misses);
        $display("Random idling on both channels, then a back-to-back stretch at the end.");
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
